@@ rtl/mabs_pkg.sv @@
package mabs_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam int WORD_W = 16;
  localparam int SLOT_W = 5;
  localparam int BIT_W  = 4;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] pattern_slot;
    logic [SLOT_W-1:0] word_slot;
    logic [WORD_W-1:0] data_word;
    logic [31:0]       selection_mask;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] entry_slot;
    logic [8:0] alarm_number;
    logic       entry_empty;
    logic       last;
  } out_beat_t;

  // Item handed from the front stage to the emitter
  typedef struct packed {
    logic              is_start;
    logic [SLOT_W-1:0] word_idx;
    logic [WORD_W-1:0] data;
    logic              last_word;
  } stage_item_t;

endpackage

@@ rtl/mabs_ram.sv @@
module mabs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 640,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mabs_front.sv @@
module mabs_front #(
  parameter int WORDS_PER_PATTERN = 20,
  parameter int PATTERN_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mabs_pkg::in_beat_t          in_data,
  output logic                        st_valid,
  output mabs_pkg::stage_item_t       st_item,
  output logic [mabs_pkg::WORD_W-1:0] st_pattern,
  input  logic                        st_take
);

  localparam int DEPTH = PATTERN_COUNT * WORDS_PER_PATTERN;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(PATTERN_COUNT);
  localparam int CW = $clog2(WORDS_PER_PATTERN + 1);

  logic          scan_on;
  logic [PW-1:0] chosen;
  logic [CW-1:0] count;

  logic          accept;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   sel_onehot;
  logic [4:0]    pick;
  logic [PW-1:0] pick_next;
  logic          last_word;
  logic          is_start;
  logic          is_status;

  assign in_ready  = !st_valid || st_take;
  assign accept    = in_valid && in_ready;
  assign is_start  = in_data.kind == mabs_pkg::KIND_START;
  assign is_status = (in_data.kind == mabs_pkg::KIND_STATUS) && scan_on;
  assign last_word = (count + 1'b1) == CW'(WORDS_PER_PATTERN);

  // Store pattern words that land inside the table
  assign we = accept && (in_data.kind == mabs_pkg::KIND_LOAD)
           && (32'(in_data.pattern_slot) < PATTERN_COUNT)
           && (32'(in_data.word_slot) < WORDS_PER_PATTERN);
  assign waddr = AW'(32'(in_data.pattern_slot) * WORDS_PER_PATTERN
                     + 32'(in_data.word_slot));

  // Fetch the pattern word for the next status word of the scan
  assign re    = accept && is_status;
  assign raddr = AW'(32'(chosen) * WORDS_PER_PATTERN + 32'(count));

  // Encode the lowest set selection bit
  assign sel_onehot = in_data.selection_mask & (~in_data.selection_mask + 32'd1);
  always_comb begin
    pick = '0;
    for (int b = 0; b < 32; b++) begin
      pick = pick | (sel_onehot[b] ? 5'(b) : 5'd0);
    end
    pick_next = (32'(pick) < PATTERN_COUNT) ? PW'(pick) : '0;
  end

  mabs_ram #(
    .WIDTH(mabs_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_data.data_word),
    .re   (re),
    .raddr(raddr),
    .rdata(st_pattern)
  );

  // Track the scan and hand start and status beats to the emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      scan_on  <= 1'b0;
      chosen   <= '0;
      count    <= '0;
    end else begin
      if (accept) begin
        st_valid           <= is_start || is_status;
        st_item.is_start   <= is_start;
        st_item.word_idx   <= 5'(count);
        st_item.data       <= in_data.data_word;
        st_item.last_word  <= last_word;
        if (is_start) begin
          chosen  <= pick_next;
          count   <= '0;
          scan_on <= 1'b1;
        end else if (is_status) begin
          count <= count + 1'b1;
          if (last_word) begin
            scan_on <= 1'b0;
          end
        end
      end else if (st_take) begin
        st_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/mabs_emit.sv @@
module mabs_emit #(
  parameter int MAX_HITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        st_valid,
  input  mabs_pkg::stage_item_t       st_item,
  input  logic [mabs_pkg::WORD_W-1:0] st_pattern,
  output logic                        st_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mabs_pkg::out_beat_t         out_data
);

  localparam int HW = $clog2(MAX_HITS + 1);

  logic                                busy;
  logic                                full;
  logic [HW-1:0]                       hits;
  logic [mabs_pkg::WORD_W-1:0]         mask;
  logic [mabs_pkg::SLOT_W-1:0]         widx;
  logic                                lastw;

  logic                                fire;
  logic [mabs_pkg::WORD_W-1:0]         low_onehot;
  logic [mabs_pkg::WORD_W-1:0]         mask_clr;
  logic [mabs_pkg::WORD_W-1:0]         both;
  logic [mabs_pkg::BIT_W-1:0]          bitpos;
  logic [HW-1:0]                       hits_inc;
  logic                                is_final;
  logic                                has_hit;

  assign st_take  = st_valid && !busy;
  assign fire     = busy && (!out_valid || out_ready);
  assign both     = st_pattern & st_item.data;
  assign has_hit  = mask != '0;
  assign hits_inc = hits + 1'b1;
  assign is_final = hits_inc == HW'(MAX_HITS);

  // Pick the lowest pending hit bit
  assign low_onehot = mask & (~mask + 1'b1);
  assign mask_clr   = mask & ~low_onehot;
  always_comb begin
    bitpos = '0;
    for (int b = 0; b < mabs_pkg::WORD_W; b++) begin
      bitpos = bitpos | (low_onehot[b] ? mabs_pkg::BIT_W'(b) : '0);
    end
  end

  // Load work, emit one entry a beat, hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      full      <= 1'b0;
      hits      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (st_take) begin
        if (st_item.is_start) begin
          hits <= '0;
          full <= 1'b0;
        end else if (!full) begin
          mask  <= both;
          widx  <= st_item.word_idx;
          lastw <= st_item.last_word;
          busy  <= (both != '0) || st_item.last_word;
        end
      end

      if (fire) begin
        out_valid              <= 1'b1;
        out_data.entry_slot    <= 3'(hits);
        out_data.alarm_number  <= has_hit ? {widx, bitpos} : 9'd0;
        out_data.entry_empty   <= !has_hit;
        out_data.last          <= is_final;
        hits                   <= hits_inc;
        mask                   <= mask_clr;
        if (is_final) begin
          busy <= 1'b0;
          full <= 1'b1;
        end else if (has_hit && (mask_clr == '0) && !lastw) begin
          busy <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/masked_alarm_bit_scanner_unit.sv @@
// Path: the front stage registers a status beat and its pattern word; the emitter
// takes it and registers each entry on out_data. Load and start beats go at one per
// cycle unless an earlier item waits on the busy emitter. The single emitter drains a
// word's entries (hits, or the fill after the last word) one a cycle unless stalled.
// Reset: synchronous, clears scan and handshake state; the pattern table is not cleared.
module masked_alarm_bit_scanner_unit #(
  parameter int MAX_HITS = 8,
  parameter int WORDS_PER_PATTERN = 20,
  parameter int PATTERN_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mabs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mabs_pkg::out_beat_t out_data
);

  logic                        st_valid;
  logic                        st_take;
  mabs_pkg::stage_item_t       st_item;
  logic [mabs_pkg::WORD_W-1:0] st_pattern;

  mabs_front #(
    .WORDS_PER_PATTERN(WORDS_PER_PATTERN),
    .PATTERN_COUNT(PATTERN_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .st_valid  (st_valid),
    .st_item   (st_item),
    .st_pattern(st_pattern),
    .st_take   (st_take)
  );

  mabs_emit #(
    .MAX_HITS(MAX_HITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .st_valid  (st_valid),
    .st_item   (st_item),
    .st_pattern(st_pattern),
    .st_take   (st_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int LIST_LEN     = 8;
  localparam int PAT_WORDS    = 20;
  localparam int PAT_COUNT    = 32;
  localparam int RANDOM_BEATS = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {BY_MODEL, NO_ENTRY, ONE_ENTRY} check_t;

  typedef struct packed {
    mabs_pkg::in_beat_t  beat;
    check_t              chk;
    mabs_pkg::out_beat_t ent;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mabs_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mabs_pkg::out_beat_t out_data;

  // Scanner state as seen by the predictor
  logic [15:0] mask_table [0:PAT_COUNT*PAT_WORDS-1];
  logic [4:0]  scan_pattern = '0;
  int          scan_word = 0;
  int          scan_hits = 0;
  bit          scan_active = 1'b0;

  mabs_pkg::out_beat_t step_out[$];
  mabs_pkg::out_beat_t entries_due[$];
  int                  loaded_pats[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int holds_done = 0;
  int hold_left = 0;
  int mismatches = 0;
  int entries_seen = 0;
  int fills_seen = 0;
  int live_beats = 0;
  int beats_sent = 0;
  int scans_started = 0;
  int cycle_count = 0;

  masked_alarm_bit_scanner_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic mabs_pkg::out_beat_t make_entry(input int slot, input int alarm,
                                                     input bit empty);
    mabs_pkg::out_beat_t e;
    e.entry_slot   = slot[2:0];
    e.alarm_number = alarm[8:0];
    e.entry_empty  = empty;
    e.last         = (slot == LIST_LEN - 1);
    return e;
  endfunction

  function automatic mabs_pkg::in_beat_t make_beat(input logic [1:0] kind,
                                                   input logic [4:0] ps,
                                                   input logic [4:0] ws,
                                                   input logic [15:0] d,
                                                   input logic [31:0] sel);
    mabs_pkg::in_beat_t b;
    b.kind           = kind;
    b.pattern_slot   = ps;
    b.word_slot      = ws;
    b.data_word      = d;
    b.selection_mask = sel;
    return b;
  endfunction

  function automatic step_row_t row(input logic [1:0] kind, input logic [4:0] ps,
                                    input logic [4:0] ws, input logic [15:0] d,
                                    input logic [31:0] sel, input check_t chk,
                                    input mabs_pkg::out_beat_t ent);
    step_row_t r;
    r.beat = make_beat(kind, ps, ws, d, sel);
    r.chk  = chk;
    r.ent  = ent;
    return r;
  endfunction

  // Advance the predicted scanner by one accepted beat; entries land in step_out
  task automatic scan_model_beat(input mabs_pkg::in_beat_t b);
    logic [15:0] both;
    int          pick;
    step_out.delete();
    case (b.kind)
      mabs_pkg::KIND_LOAD: begin
        if (b.word_slot < PAT_WORDS) begin
          mask_table[10'(b.pattern_slot * PAT_WORDS + b.word_slot)] = b.data_word;
          live_beats++;
        end
      end
      mabs_pkg::KIND_START: begin
        // lowest set bit wins; no bit (or one past the table) means pattern 0
        pick = 0;
        for (int i = 31; i >= 0; i--)
          if (b.selection_mask[i]) pick = i;
        if (pick >= PAT_COUNT) pick = 0;
        scan_pattern = pick[4:0];
        scan_word    = 0;
        scan_hits    = 0;
        scan_active  = 1'b1;
        live_beats++;
        scans_started++;
      end
      mabs_pkg::KIND_STATUS: begin
        if (scan_active) begin
          live_beats++;
          both = mask_table[10'(scan_pattern * PAT_WORDS + scan_word)] & b.data_word;
          for (int i = 0; i < 16 && scan_active; i++) begin
            if (both[i]) begin
              step_out.push_back(make_entry(scan_hits, scan_word * 16 + i, 1'b0));
              scan_hits++;
              // list full: end the scan on the spot, no fill
              if (scan_hits >= LIST_LEN) scan_active = 1'b0;
            end
          end
          if (scan_active) begin
            scan_word++;
            if (scan_word >= PAT_WORDS) begin
              while (scan_hits < LIST_LEN) begin
                step_out.push_back(make_entry(scan_hits, 0, 1'b1));
                scan_hits++;
              end
              scan_active = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one beat, hold it until taken, then queue what it should produce
  task automatic send_beat(input mabs_pkg::in_beat_t b, input check_t chk,
                           input mabs_pkg::out_beat_t ent);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    beats_sent++;
    scan_model_beat(b);
    if (chk == BY_MODEL) begin
      foreach (step_out[i]) entries_due.push_back(step_out[i]);
    end else if (chk == ONE_ENTRY) begin
      entries_due.push_back(ent);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send(input mabs_pkg::in_beat_t b);
    send_beat(b, BY_MODEL, '0);
  endtask

  // Drop valid and wait until every queued entry has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
  endtask

  // Write all words of one pattern in a scrambled order
  task automatic load_pattern(input int p, input logic [15:0] keep);
    int first;
    first = $urandom_range(PAT_WORDS - 1);
    for (int k = 0; k < PAT_WORDS; k++)
      send(make_beat(mabs_pkg::KIND_LOAD, p[4:0], 5'((first + 7 * k) % PAT_WORDS),
                     16'($urandom) & keep, $urandom));
    loaded_pats.push_back(p);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send(make_beat(mabs_pkg::KIND_LOAD,
                        5'(loaded_pats[$urandom_range(loaded_pats.size() - 1)]),
                        5'($urandom_range(PAT_WORDS - 1)), 16'($urandom), $urandom));
      1: send(make_beat(mabs_pkg::KIND_LOAD, 5'($urandom),
                        5'($urandom_range(PAT_WORDS, 31)), 16'($urandom), $urandom));
      default: send(make_beat(KIND_UNUSED, 5'($urandom), 5'($urandom), 16'($urandom),
                              $urandom));
    endcase
  endtask

  // One start beat on a loaded pattern, then a run of status words
  task automatic run_scan();
    int          p;
    int          words;
    int          density;
    logic [31:0] sel;
    logic [15:0] d;
    p   = loaded_pats[$urandom_range(loaded_pats.size() - 1)];
    sel = (($urandom >> (p + 1)) << (p + 1)) | (32'h1 << p);
    if (p == 0 && $urandom_range(3) == 0) sel = '0;
    send(make_beat(mabs_pkg::KIND_START, 5'($urandom), 5'($urandom), 16'($urandom), sel));
    words   = ($urandom_range(9) < 7) ? PAT_WORDS : $urandom_range(1, PAT_WORDS - 1);
    density = $urandom_range(5);
    for (int w = 0; w < words; w++) begin
      if ($urandom_range(9) == 0) send_noise();
      d = 16'($urandom);
      repeat (density) d &= 16'($urandom);
      send(make_beat(mabs_pkg::KIND_STATUS, 5'($urandom), 5'($urandom), d, $urandom));
    end
  endtask

  // Receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (holds_done != hold_asks) begin
      holds_done = hold_asks;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic cmp_field(input string name, input logic [8:0] want_v,
                           input logic [8:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Check each output beat against the oldest queued entry
  always @(posedge clk) begin : entry_check
    mabs_pkg::out_beat_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (entries_due.size() == 0) begin
        $error("entry with nothing due: slot %0d alarm %0d empty %0b last %0b",
               out_data.entry_slot, out_data.alarm_number, out_data.entry_empty,
               out_data.last);
        mismatches++;
      end else begin
        want = entries_due.pop_front();
        cmp_field("entry_slot", 9'(want.entry_slot), 9'(out_data.entry_slot));
        cmp_field("alarm_number", want.alarm_number, out_data.alarm_number);
        cmp_field("entry_empty", 9'(want.entry_empty), 9'(out_data.entry_empty));
        cmp_field("last", 9'(want.last), 9'(out_data.last));
        entries_seen++;
        if (want.entry_empty) fills_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d entries outstanding", cycle_count,
               entries_due.size());
      $display("masked_alarm_bit_scanner_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t steps[$];
    int        base;
    int        phase;
    int        cur_phase;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill pattern 0 with random bits and pattern 31 with zeros
    load_pattern(0, 16'hFFFF);
    load_pattern(31, 16'h0000);

    // Directed beats: idle status, unused kind, rejected loads, restarts, list full
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(KIND_UNUSED, 5'd31, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_LOAD, 5'd31, 5'd20, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_LOAD, 5'd31, 5'd31, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_LOAD, 5'd31, 5'd0, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_START, 5'd0, 5'd0, 16'h0, 32'h8000_0000,
                        NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'h8000, 32'h0, ONE_ENTRY,
                        make_entry(0, 15, 1'b0)));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_START, 5'd0, 5'd0, 16'h0, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'hFFFF, 32'h0, BY_MODEL, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'h0000, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_START, 5'd0, 5'd0, 16'h0, 32'hFFFF_FFFF,
                        NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'h0001, 32'h0, BY_MODEL, '0));
    steps.push_back(row(mabs_pkg::KIND_START, 5'd0, 5'd0, 16'h0, 32'h8000_0000,
                        NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'h0001, 32'h0, ONE_ENTRY,
                        make_entry(0, 0, 1'b0)));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_LOAD, 5'd31, 5'd2, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'hFFFF, 32'h0, BY_MODEL, '0));
    steps.push_back(row(mabs_pkg::KIND_STATUS, 5'd0, 5'd0, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    steps.push_back(row(mabs_pkg::KIND_LOAD, 5'd0, 5'd19, 16'hFFFF, 32'h0, NO_ENTRY, '0));
    foreach (steps[i]) send_beat(steps[i].beat, steps[i].chk, steps[i].ent);

    // Random scans in four traffic phases
    base      = beats_sent;
    cur_phase = -1;
    while (beats_sent - base < RANDOM_BEATS) begin
      phase = (beats_sent - base) * 4 / RANDOM_BEATS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        case (phase)
          0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
            hold_asks++;
            load_pattern($urandom_range(1, PAT_COUNT - 2), 16'hFFFF);
          end
          1: begin
            send_idle_pct = 57;
            stall_pct     = 0;
          end
          2: begin
            drain();
            send_idle_pct = 0;
            stall_pct     = 57;
          end
          default: begin
            send_idle_pct = 8;
            stall_pct     = 8;
            load_pattern($urandom_range(1, PAT_COUNT - 2), 16'hFFFF);
          end
        endcase
      end
      run_scan();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d beats sent, %0d scans over %0d loaded patterns, %0d that changed state",
             beats_sent, scans_started, loaded_pats.size(), live_beats);
    $display("%0d list entries checked, %0d of them fill", entries_seen, fills_seen);
    if (mismatches == 0) begin
      $display("masked_alarm_bit_scanner_unit verification clean");
    end else begin
      $display("masked_alarm_bit_scanner_unit verification failed");
    end
    $finish;
  end

endmodule
